FILE: design/gwwl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Greedy word-wrap line breaker: shared package
// Item types, register indexes and constants shared by the line breaker.
// ----------------------------------------------------------------------------
package gwwl_pkg;

  localparam int MAX_LETTERS = 4096;
  localparam int INDEX_LIMIT = (MAX_LETTERS < 4096 ? MAX_LETTERS : 4096) - 1;
  localparam int RESULT_QUEUE_DEPTH = 4;

  localparam logic [20:0] CODE_NEWLINE = 21'd10;
  localparam logic [20:0] CODE_SPACE   = 21'd32;

  localparam logic REG_MAX_WIDTH      = 1'b0;
  localparam logic REG_LETTER_SPACING = 1'b1;

  typedef struct packed {
    logic [20:0] letter_code;
    logic [7:0]  glyph_width;
    logic        last_letter;
  } in_item_t;

  typedef struct packed {
    logic [11:0] line_start;
    logic [12:0] line_letters;
    logic        final_line;
  } out_item_t;

  // Lines produced by one letter, in order; count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } line_push_t;

endpackage
`default_nettype wire

FILE: design/gwwl_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Greedy word-wrap line breaker: line queue
// Small queue that takes up to two lines per cycle and hands one out per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module gwwl_queue #(
  parameter int Depth = gwwl_pkg::RESULT_QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire gwwl_pkg::line_push_t  push,
  output logic                       room,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output gwwl_pkg::out_item_t        out_data
);
  import gwwl_pkg::*;

  localparam int PtrW   = (Depth > 2) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  out_item_t           mem [Depth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     wr_ptr_p1;
  logic [PtrW-1:0]     wr_ptr_p2;
  logic [PtrW-1:0]     rd_ptr;
  logic [PtrW-1:0]     rd_ptr_next;
  logic [CountW-1:0]   count;
  logic [CountW-1:0]   count_next;
  logic                pop;

  function automatic logic [PtrW-1:0] step_ptr(input logic [PtrW-1:0] p);
    step_ptr = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_ptr_p1   = step_ptr(wr_ptr);
  assign wr_ptr_p2   = step_ptr(wr_ptr_p1);
  assign rd_ptr_next = step_ptr(rd_ptr);
  assign pop         = out_valid && out_ready;
  assign out_valid   = (count != '0);
  assign out_data    = mem[rd_ptr];
  assign room        = (count <= CountW'(Depth - 2));
  assign count_next  = count + CountW'(push.count) - CountW'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_p1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      case (push.count)
        2'd1:    wr_ptr <= wr_ptr_p1;
        2'd2:    wr_ptr <= wr_ptr_p2;
        default: wr_ptr <= wr_ptr;
      endcase
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      count <= count_next;
    end
  end

  // The queue never holds more lines than it has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(Depth))
    else $error("line queue over-full");

  // A pair of lines is only pushed when two entries are free.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> room)
    else $error("line pushed without room");

  // Occupancy follows pushes and pops.
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + CountW'($past(push.count)) - CountW'($past(pop)))
    else $error("line queue count drift");

endmodule
`default_nettype wire

FILE: design/greedy_word_wrap_line_breaker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Greedy word-wrap line breaker: top level
// Splits a stream of letters into lines at newlines and at width overflow.
// ----------------------------------------------------------------------------
// The block takes one letter per cycle while the line queue has room and
// reports each finished line as its first letter index and its letter
// count. A letter request is held in an input register and processed
// against the running line state once the queue has room; the lines it
// finishes go into a line queue (four entries by default) and are offered
// on the output from there. Throughput is one letter per cycle while the
// output is taken every cycle; the queue's single read port hands out one
// line per cycle, so a final letter that closes two lines has them go out
// of the queue one after the other. Letters wait only when fewer than two
// queue entries are free. Configuration writes are always accepted and
// should be made while no letter is in flight; a max_width of zero turns wrapping off.
module greedy_word_wrap_line_breaker_top #(
  parameter int QUEUE_DEPTH = gwwl_pkg::RESULT_QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire gwwl_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output gwwl_pkg::out_item_t       out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_index,
  input  wire logic [15:0]          cfg_data
);
  import gwwl_pkg::*;

  localparam logic [11:0] IndexLimit = 12'(INDEX_LIMIT);

  // Configuration registers.
  logic [15:0] max_width;
  logic [7:0]  letter_spacing;

  // Input register.
  logic        item_valid;
  in_item_t    item;

  // Line state.
  logic [11:0] letter_index;
  logic [11:0] start_index;
  logic [11:0] space_index;
  logic [23:0] line_width;
  logic [23:0] width_since_space;

  logic [11:0] letter_index_next;
  logic [11:0] start_index_next;
  logic [11:0] space_index_next;
  logic [23:0] line_width_next;
  logic [23:0] width_since_space_next;

  line_push_t  push;
  logic        room;
  logic        fire;

  function automatic logic [11:0] sat_index(input logic [12:0] v);
    sat_index = (v > {1'b0, IndexLimit}) ? IndexLimit : v[11:0];
  endfunction

  function automatic logic [23:0] sat_width(input logic [24:0] v);
    sat_width = v[24] ? 24'hFF_FFFF : v[23:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign fire      = item_valid && room;
  assign in_ready  = !item_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_width      <= '0;
      letter_spacing <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAX_WIDTH:      max_width      <= cfg_data;
        REG_LETTER_SPACING: letter_spacing <= cfg_data[7:0];
        default:            max_width      <= max_width;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_data;
    end
  end

  // One letter's step: newline or space first, then the width test, then the
  // close of the text. Lines fill the first slot, then the second.
  always_comb begin
    logic [11:0] idx;
    logic [11:0] start0;
    logic [23:0] lw0;
    logic [23:0] ws0;
    logic [8:0]  len;
    logic [24:0] lw_sum;
    logic        over;
    logic [12:0] total;
    out_item_t   line;
    logic        emit;

    idx    = letter_index;
    start0 = start_index;
    lw0    = line_width;
    ws0    = width_since_space;
    space_index_next = space_index;
    push = '0;

    if (item.letter_code == CODE_NEWLINE) begin
      push.count        = 2'd1;
      push.first        = '0;
      push.first.line_start   = start0;
      push.first.line_letters = {1'b0, idx} - {1'b0, start0};
      start0 = sat_index({1'b0, idx} + 13'd1);
      lw0    = '0;
      ws0    = '0;
    end else if (item.letter_code == CODE_SPACE) begin
      space_index_next = idx;
      ws0 = '0;
    end

    len    = {1'b0, item.glyph_width} + {1'b0, letter_spacing};
    lw_sum = {1'b0, lw0} + {16'd0, len};
    over   = (max_width != '0) && (lw_sum >= {9'd0, max_width});

    start_index_next       = start0;
    line_width_next        = lw0;
    width_since_space_next = ws0;
    line = '0;
    emit = 1'b0;

    if (over) begin
      if (space_index_next > start0) begin
        emit = 1'b1;
        line.line_start   = start0;
        line.line_letters = {1'b0, space_index_next} - {1'b0, start0};
        start_index_next  = sat_index({1'b0, space_index_next} + 13'd1);
        line_width_next   = ws0;
      end else if (idx > start0) begin
        emit = 1'b1;
        line.line_start        = start0;
        line.line_letters      = {1'b0, idx} - {1'b0, start0};
        start_index_next       = idx;
        line_width_next        = {15'd0, len};
        width_since_space_next = {15'd0, len};
      end
    end else begin
      line_width_next        = sat_width(lw_sum);
      width_since_space_next = sat_width({1'b0, ws0} + {16'd0, len});
    end

    if (emit) begin
      if (push.count == 2'd0) begin
        push.first = line;
      end else begin
        push.second = line;
      end
      push.count = push.count + 2'd1;
    end

    total = {1'b0, idx} + 13'd1;
    line  = '0;
    if (item.last_letter) begin
      if ((total > {1'b0, start_index_next}) && (push.count != 2'd2)) begin
        line.line_start   = start_index_next;
        line.line_letters = total - {1'b0, start_index_next};
        if (push.count == 2'd0) begin
          push.first = line;
        end else begin
          push.second = line;
        end
        push.count = push.count + 2'd1;
      end
      case (push.count)
        2'd1:    push.first.final_line  = 1'b1;
        2'd2:    push.second.final_line = 1'b1;
        default: push.first.final_line  = 1'b0;
      endcase
      letter_index_next      = '0;
      start_index_next       = '0;
      space_index_next       = '0;
      line_width_next        = '0;
      width_since_space_next = '0;
    end else begin
      letter_index_next = sat_index({1'b0, idx} + 13'd1);
    end

    if (!fire) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      letter_index      <= '0;
      start_index       <= '0;
      space_index       <= '0;
      line_width        <= '0;
      width_since_space <= '0;
    end else if (fire) begin
      letter_index      <= letter_index_next;
      start_index       <= start_index_next;
      space_index       <= space_index_next;
      line_width        <= line_width_next;
      width_since_space <= width_since_space_next;
    end
  end

  gwwl_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // The last letter of a text returns the line state to its starting point.
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (fire && item.last_letter) |=> (letter_index == '0) && (start_index == '0))
    else $error("line state not cleared at end of text");

  // Line state moves only when a letter is processed.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(letter_index) && $stable(start_index) && $stable(line_width))
    else $error("line state changed without a letter");

  // Below the limit the letter index counts up by one per letter.
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (fire && !item.last_letter && (letter_index != IndexLimit))
      |=> letter_index == $past(letter_index) + 12'd1)
    else $error("letter index skipped");

endmodule
`default_nettype wire

FILE: verif/line_break_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line breaker checker
// Watches the letter, line and register channels of the word-wrap line
// breaker, works out the lines each letter should finish and compares them
// in order with the lines that the block hands out.
// ----------------------------------------------------------------------------
module line_break_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  gwwl_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  gwwl_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data,
  output int                  failures,
  output int                  lines_pending
);
  import gwwl_pkg::*;

  localparam int unsigned WIDTH_CAP = 32'h00FF_FFFF;

  // Register copies and running line state, kept at full integer width.
  int unsigned max_width;
  int unsigned spacing;
  int unsigned letter_index;
  int unsigned start_index;
  int unsigned space_index;
  int unsigned line_width;
  int unsigned width_since_space;

  out_item_t pending_lines [$];
  out_item_t oldest;

  initial begin
    failures      = 0;
    lines_pending = 0;
  end

  function automatic int unsigned sat_index(input int unsigned v);
    return (v > INDEX_LIMIT) ? INDEX_LIMIT : v;
  endfunction

  function automatic int unsigned sat_width(input int unsigned v);
    return (v > WIDTH_CAP) ? WIDTH_CAP : v;
  endfunction

  function automatic out_item_t make_line(input int unsigned first, input int unsigned count);
    out_item_t line;
    line.line_start   = first[11:0];
    line.line_letters = count[12:0];
    line.final_line   = 1'b0;
    return line;
  endfunction

  task automatic clear_line_state();
    letter_index      = 0;
    start_index       = 0;
    space_index       = 0;
    line_width        = 0;
    width_since_space = 0;
  endtask

  // Works out the lines that one letter finishes and queues them in order.
  task automatic predict_lines(input in_item_t item);
    int unsigned idx;
    int unsigned len;
    int unsigned total;
    int          n;
    out_item_t   lines [2];
    idx = letter_index;
    n   = 0;
    if (item.letter_code == CODE_NEWLINE) begin
      lines[n]          = make_line(start_index, idx - start_index);
      n++;
      start_index       = sat_index(idx + 1);
      line_width        = 0;
      width_since_space = 0;
    end else if (item.letter_code == CODE_SPACE) begin
      space_index       = idx;
      width_since_space = 0;
    end
    len = 32'(item.glyph_width) + spacing;
    if (max_width != 0 && line_width + len >= max_width) begin
      if (space_index > start_index) begin
        lines[n]    = make_line(start_index, space_index - start_index);
        n++;
        start_index = sat_index(space_index + 1);
        line_width  = width_since_space;
      end else if (idx > start_index) begin
        lines[n]          = make_line(start_index, idx - start_index);
        n++;
        start_index       = idx;
        line_width        = len;
        width_since_space = len;
      end
    end else begin
      line_width        = sat_width(line_width + len);
      width_since_space = sat_width(width_since_space + len);
    end
    if (item.last_letter) begin
      total = idx + 1;
      if (total > start_index && n < 2) begin
        lines[n] = make_line(start_index, total - start_index);
        n++;
      end
      if (n > 0) lines[n-1].final_line = 1'b1;
      clear_line_state();
    end else begin
      letter_index = sat_index(idx + 1);
    end
    for (int i = 0; i < n; i++) pending_lines = {pending_lines, lines[i]};
  endtask

  always @(posedge clk) begin
    if (rst) begin
      max_width = 0;
      spacing   = 0;
      clear_line_state();
      pending_lines.delete();
    end else begin
      // Lines are checked before the letter of this edge is predicted, so a
      // line can never be matched against an expectation raised in the same
      // cycle.
      if (out_valid && out_ready) begin
        if (pending_lines.size() == 0) begin
          failures++;
          $display("%0t: unexpected line: expected none, got start %0d letters %0d final %0b",
                   $time, out_data.line_start, out_data.line_letters, out_data.final_line);
        end else begin
          oldest = pending_lines.pop_front();
          if (out_data.line_start !== oldest.line_start) begin
            failures++;
            $display("%0t: line_start mismatch: expected %0d, got %0d",
                     $time, oldest.line_start, out_data.line_start);
          end
          if (out_data.line_letters !== oldest.line_letters) begin
            failures++;
            $display("%0t: line_letters mismatch: expected %0d, got %0d",
                     $time, oldest.line_letters, out_data.line_letters);
          end
          if (out_data.final_line !== oldest.final_line) begin
            failures++;
            $display("%0t: final_line mismatch: expected %0b, got %0b",
                     $time, oldest.final_line, out_data.final_line);
          end
        end
      end
      if (in_valid && in_ready) predict_lines(in_data);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAX_WIDTH) max_width = 32'(cfg_data);
        else if (cfg_index == REG_LETTER_SPACING) spacing = 32'(cfg_data[7:0]);
      end
    end
    lines_pending = pending_lines.size();
  end

endmodule

FILE: verif/greedy_word_wrap_line_breaker_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word-wrap line breaker testbench
// Feeds the line breaker with directed and random texts under several width
// settings and handshake patterns; a checker beside the block predicts every
// line and compares it with what the block hands out.
// ----------------------------------------------------------------------------
module greedy_word_wrap_line_breaker_top_test;
  import gwwl_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int LIMIT_CYCLES  = 600_000;
  // The first line of a letter is offered after its request has passed the
  // input register and the line queue; spare cycles cover letters that finish no line at all.
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int PER_SETTING   = 125;

  localparam logic [20:0] CODE_A = 21'd97;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_MAX_WIDTH;
  logic [15:0] cfg_data  = '0;

  int failures;
  int lines_pending;

  // Handshake pressure and stimulus counters; the stall and hold-off values are read by the line receiver.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_trigger  = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int letters_sent  = 0;
  int setting_no    = 0;

  greedy_word_wrap_line_breaker_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  line_break_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .failures      (failures),
    .lines_pending (lines_pending)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Line receiver. It stalls at random at the rate of the current phase, and
  // whenever the stimulus asks for a hold-off it refuses every line for a long
  // stretch, counted here, so that the line queue fills and letters back up.
  always @(negedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen = hold_trigger;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offers one letter request and returns at the falling edge after it has
  // been taken. Valid is left high so that a following request can go out
  // back to back; anything that pauses the sender lowers it first.
  task automatic send_letter(input logic [20:0] code, input logic [7:0] glyph,
                             input logic last);
    in_item_t item;
    item.letter_code = code;
    item.glyph_width = glyph;
    item.last_letter = last;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    letters_sent++;
    @(negedge clk);
  endtask

  // Stops the sender and waits until every predicted line has been taken,
  // then gives the block time to finish a letter that produces no line.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (lines_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic index, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Register writes only happen with the block idle. The upper byte of the
  // spacing write carries random bits that the block must ignore.
  task automatic apply_settings(input logic [15:0] width_limit, input logic [7:0] gap);
    wait_drained();
    write_register(REG_MAX_WIDTH, width_limit);
    write_register(REG_LETTER_SPACING, {8'($urandom), gap});
  endtask

  // A random text: words of lower-case letters separated mostly by spaces and
  // now and then by newlines, with a share of arbitrary code points that break
  // the pattern. The final letter carries the end-of-text flag.
  task automatic send_text(input int letters, input int glyph_hi, input int noise_pct);
    int          word_left;
    int          pick;
    logic [20:0] code;
    logic [7:0]  glyph;
    word_left = $urandom_range(1, 10);
    for (int i = 0; i < letters; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < noise_pct) begin
        code = 21'($urandom_range(0, 1114111));
      end else if (word_left == 0) begin
        code      = ($urandom_range(0, 99) < 15) ? CODE_NEWLINE : CODE_SPACE;
        word_left = $urandom_range(1, 10);
      end else begin
        code = CODE_A + 21'($urandom_range(0, 25));
        word_left--;
      end
      glyph = ($urandom_range(0, 19) == 0) ? 8'd255 : 8'($urandom_range(0, glyph_hi));
      send_letter(code, glyph, i == letters - 1);
    end
  endtask

  // One width setting per call, cycling through the extremes and random
  // values of both registers.
  task automatic next_settings();
    logic [15:0] width_limit;
    logic [7:0]  gap;
    case (setting_no % 5)
      0:       width_limit = 16'd0;
      1:       width_limit = 16'd1;
      2:       width_limit = 16'hFFFF;
      3:       width_limit = 16'($urandom_range(2, 600));
      default: width_limit = 16'($urandom_range(600, 65535));
    endcase
    case (setting_no % 3)
      0:       gap = 8'd0;
      1:       gap = 8'd255;
      default: gap = 8'($urandom_range(0, 255));
    endcase
    setting_no++;
    apply_settings(width_limit, gap);
  endtask

  task automatic send_random_texts(input int count);
    int target;
    int length;
    int glyph_hi;
    target = letters_sent + count;
    while (letters_sent < target) begin
      case ($urandom_range(0, 19))
        0, 1:    length = $urandom_range(1, 3);
        2, 3, 4: length = $urandom_range(30, 120);
        default: length = $urandom_range(4, 30);
      endcase
      case ($urandom_range(0, 2))
        0:       glyph_hi = 255;
        1:       glyph_hi = 60;
        default: glyph_hi = 15;
      endcase
      send_text(length, glyph_hi, ($urandom_range(0, 3) == 0) ? 20 : 3);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed texts with a 600 pixel limit and no spacing: a cut at a
    // space, a cut in the middle of a word, a newline, and a final letter
    // that finishes two lines at once.
    apply_settings(16'd600, 8'd0);
    send_letter(CODE_A,            8'd255, 1'b0);
    send_letter(CODE_A + 21'd1,    8'd255, 1'b0);
    send_letter(CODE_SPACE,        8'd255, 1'b0);
    send_letter(CODE_A + 21'd2,    8'd255, 1'b0);
    send_letter(CODE_A + 21'd3,    8'd255, 1'b0);
    send_letter(CODE_A + 21'd4,    8'd255, 1'b0);
    send_letter(CODE_NEWLINE,      8'd0,   1'b0);
    send_letter(CODE_A + 21'd23,   8'd255, 1'b0);
    send_letter(CODE_A + 21'd24,   8'd255, 1'b0);
    send_letter(CODE_A + 21'd25,   8'd255, 1'b1);
    // Texts of a single letter: a lone newline, and both ends of the code
    // range.
    send_letter(CODE_NEWLINE, 8'd0,   1'b1);
    send_letter(21'd1114111,  8'd255, 1'b1);
    send_letter(21'd0,        8'd0,   1'b1);

    // A one pixel limit with full spacing: the first letter overflows with
    // nothing to cut, and a stale space behind the line start is ignored.
    apply_settings(16'd1, 8'd255);
    send_letter(CODE_A + 21'd16, 8'd0, 1'b0);
    send_letter(CODE_SPACE,      8'd0, 1'b0);
    send_letter(CODE_A + 21'd17, 8'd0, 1'b1);

    apply_settings(16'hFFFF, 8'd255);
    send_letter(CODE_A + 21'd12, 8'd255, 1'b0);
    send_letter(CODE_NEWLINE,    8'd255, 1'b0);
    send_letter(CODE_A + 21'd13, 8'd255, 1'b0);
    send_letter(CODE_A + 21'd14, 8'd255, 1'b1);

    // Random phases. Each phase has its own idling pattern and two width
    // settings; changing the setting drains the block, which also pauses the
    // sender until every expected line has been taken.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 81; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 81; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      for (int s = 0; s < 2; s++) begin
        next_settings();
        if (phase == 0 && s == 0) begin
          // Long receiver hold-off while the sender keeps offering letters,
          // so that lines pile up and letters stall.
          hold_trigger++;
          send_text(60, 255, 0);
        end
        send_random_texts(PER_SETTING);
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(2 * HALF_PERIOD * LIMIT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: sim.f
design/gwwl_pkg.sv
design/gwwl_queue.sv
design/greedy_word_wrap_line_breaker_top.sv
verif/line_break_checker.sv
verif/greedy_word_wrap_line_breaker_top_test.sv
